[hw/rtl/sisu_pkg.sv]
`default_nettype none

package sisu_pkg;

  localparam int unsigned MUL_W   = 64;
  localparam int unsigned PROD_W  = 2 * MUL_W;
  localparam int unsigned DIV_N_W = 96;
  localparam int unsigned DIV_D_W = 64;
  localparam int unsigned PADDR_W = 3;

  localparam logic [63:0] LIM             = 64'h2000_0000_0000_0000;
  localparam logic [31:0] FOURTEEN_Q16    = 32'h000E_0000;
  localparam logic [63:0] ONE_Q40         = 64'h0000_0100_0000_0000;
  localparam logic [63:0] HALF_PI_Q60     = 64'h1921_FB54_442D_1847;
  localparam logic [63:0] HALF_PI_Q40     = 64'h0000_0192_1FB5_4443;
  localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9_836E_4E44_152A;
  localparam logic [95:0] ONE_Q56         = 96'h1 << 56;
  localparam logic [4:0]  TAYLOR_LAST     = 5'd21;
  localparam logic [15:0] THR_RESET       = 16'd5363;

  localparam logic REG_TERM_THRESHOLD = 1'b0;

  typedef enum logic [18:0] {
    S_IDLE  = 19'd1 << 0,
    S_SQ    = 19'd1 << 1,
    S_PM    = 19'd1 << 2,
    S_PNUM  = 19'd1 << 3,
    S_PDEN  = 19'd1 << 4,
    S_PDIV  = 19'd1 << 5,
    S_AM    = 19'd1 << 6,
    S_AD    = 19'd1 << 7,
    S_GINIT = 19'd1 << 8,
    S_RED   = 19'd1 << 9,
    S_PHI   = 19'd1 << 10,
    S_TACC  = 19'd1 << 11,
    S_TM    = 19'd1 << 12,
    S_TDIV  = 19'd1 << 13,
    S_SDF   = 19'd1 << 14,
    S_MF    = 19'd1 << 15,
    S_SDG   = 19'd1 << 16,
    S_MG    = 19'd1 << 17,
    S_FIN   = 19'd1 << 18
  } state_e;

  function automatic logic [63:0] sat_lim(input logic [PROD_W-1:0] v);
    logic [63:0] r;
    r = (v > {64'd0, LIM}) ? LIM : v[63:0];
    return r;
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] acc,
                                                 input logic [63:0] mag,
                                                 input logic sub);
    logic signed [63:0] v;
    v = sub ? acc - $signed(mag) : acc + $signed(mag);
    if (v > $signed(LIM)) begin
      v = $signed(LIM);
    end else if (v < -$signed(LIM)) begin
      v = -$signed(LIM);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sisu_x_if.sv]
`default_nettype none

interface sisu_x_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_value;

  modport source(output valid, output x_value, input ready);
  modport sink(input valid, input x_value, output ready);
endinterface

`default_nettype wire

[hw/rtl/sisu_si_if.sv]
`default_nettype none

interface sisu_si_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] si_value;

  modport source(output valid, output si_value, input ready);
  modport sink(input valid, input si_value, output ready);
endinterface

`default_nettype wire

[hw/rtl/sisu_mul.sv]
`default_nettype none

module sisu_mul (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [sisu_pkg::MUL_W-1:0]  a_i,
  input  wire logic [sisu_pkg::MUL_W-1:0]  b_i,
  output logic                             done_o,
  output logic [sisu_pkg::PROD_W-1:0]      prod_o
);

  logic                          busy_q;
  logic [2:0]                    cnt_q;
  logic                          done_q;
  logic [sisu_pkg::MUL_W-1:0]    a_q, b_q;
  logic [63:0]                   pp_q;
  logic [sisu_pkg::PROD_W-1:0]   acc_q;
  logic [31:0]                   au, bu;
  logic [sisu_pkg::PROD_W-1:0]   ppx;

  assign au = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign bu = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  always_comb begin
    case (cnt_q)
      3'd1:       ppx = {64'd0, pp_q};
      3'd2, 3'd3: ppx = {32'd0, pp_q, 32'd0};
      3'd4:       ppx = {pp_q, 64'd0};
      default:    ppx = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q <= au * bu;
      end
      acc_q <= acc_q + ppx;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

[hw/rtl/sisu_div.sv]
`default_nettype none

module sisu_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [sisu_pkg::DIV_N_W-1:0]  num_i,
  input  wire logic [sisu_pkg::DIV_D_W-1:0]  den_i,
  output logic                               done_o,
  output logic [sisu_pkg::DIV_N_W-1:0]       quot_o
);

  localparam int unsigned CW = $clog2(sisu_pkg::DIV_N_W);

  logic                           busy_q;
  logic [CW-1:0]                  cnt_q;
  logic                           done_q;
  logic [sisu_pkg::DIV_D_W-1:0]   rem_q, den_q;
  logic [sisu_pkg::DIV_N_W-1:0]   qn_q;
  logic [sisu_pkg::DIV_D_W:0]     rsh;
  logic [sisu_pkg::DIV_D_W:0]     rsub;
  logic                           qbit;

  assign rsh  = {rem_q, qn_q[sisu_pkg::DIV_N_W-1]};
  assign rsub = rsh - {1'b0, den_q};
  assign qbit = (rsh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(sisu_pkg::DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      qn_q  <= num_i;
    end else if (busy_q) begin
      rem_q <= qbit ? rsub[sisu_pkg::DIV_D_W-1:0] : rsh[sisu_pkg::DIV_D_W-1:0];
      qn_q  <= {qn_q[sisu_pkg::DIV_N_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = qn_q;

endmodule

`default_nettype wire

[hw/rtl/sine_integral_series_unit.sv]
`default_nettype none
// Sine integral Si(x) of a Q16.16 argument, result in Q2.29, saturated.
// Channels: x_i takes one word (x_value), si_o returns one word (si_value)
// per input word. Both use valid/ready; a word moves when both are high.
// The APB port holds term_threshold at byte address 0 (units 2^-29).
// x_i.ready is high only while the sequencer is idle; one word is worked on
// at a time by a shared 64x64 multiplier and a radix-2 divider.
// For |x| <= 14 a power series is summed; for |x| > 14 two asymptotic series
// are summed, then the sine/cosine and the final combination are formed.
// Each series stops at term_threshold or after MAX_TERMS terms (default 64).
// The result waits in an output register; the next word is accepted while it
// waits, and a new result stalls only when that register is still full.
// Reset clears the sequencer, the output valid and sets term_threshold to
// 5363.

module sine_integral_series_unit #(
  parameter int unsigned MAX_TERMS = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  sisu_x_if.sink                            x_i,
  sisu_si_if.source                         si_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sisu_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned NW = $clog2(MAX_TERMS);

  sisu_pkg::state_e state_q, state_d;
  logic               issued_q, issued_d;
  logic               ovalid_q, ovalid_d;
  logic [15:0]        thr_q;
  logic [31:0]        out_q, out_d;

  logic [31:0]        a_q, a_d;
  logic               neg_q, neg_d;
  logic [63:0]        a2_q, a2_d;
  logic [26:0]        lim_q, lim_d;
  logic [63:0]        term_q, term_d;
  logic signed [63:0] sum_q, sum_d;
  logic signed [63:0] f_q, f_d;
  logic [NW-1:0]      n_q, n_d;
  logic               odd_q, odd_d;
  logic [63:0]        p_q, p_d;
  logic [95:0]        dvd_q, dvd_d;
  logic [63:0]        den_q, den_d;
  logic [1:0]         quad_q, quad_d;
  logic [39:0]        phr_q, phr_d;
  logic [63:0]        phi_q, phi_d;
  logic signed [63:0] s0_q, s0_d, c0_q, c0_d;
  logic [4:0]         j_q, j_d;
  logic [63:0]        tmp_q, tmp_d;
  logic               tneg_q, tneg_d;
  logic signed [63:0] acc_q, acc_d;

  logic               mul_use, div_use, mul_start, div_start, mul_done, div_done;
  logic [63:0]        mul_a, mul_b;
  logic [127:0]       prod;
  logic [95:0]        div_n, quot;
  logic [63:0]        div_d;

  logic [NW:0]        twon, alt;
  logic [2*NW+1:0]    kf;
  logic signed [63:0] sn, cs;
  logic [63:0]        sn_mag, cs_mag, f_mag, g_mag;
  logic [63:0]        tq, mq40;
  logic signed [63:0] sum_new, prod_s;
  logic signed [63:0] vs;
  logic [63:0]        vmag;
  logic [52:0]        mr;
  logic [31:0]        rounded;
  logic               cfg_wr;

  assign twon = {n_q, 1'b0};
  assign alt  = odd_q ? twon + (NW+1)'(1) : twon - (NW+1)'(1);
  assign kf   = twon * alt;

  always_comb begin
    case (quad_q)
      2'd0:    begin sn = s0_q;  cs = c0_q;  end
      2'd1:    begin sn = c0_q;  cs = -s0_q; end
      2'd2:    begin sn = -s0_q; cs = -c0_q; end
      default: begin sn = -c0_q; cs = s0_q;  end
    endcase
  end

  assign sn_mag = sn[63] ? 64'(-sn) : 64'(sn);
  assign cs_mag = cs[63] ? 64'(-cs) : 64'(cs);
  assign f_mag  = f_q[63] ? 64'(-f_q) : 64'(f_q);
  assign g_mag  = sum_q[63] ? 64'(-sum_q) : 64'(sum_q);

  always_comb begin
    mul_use = 1'b0;
    div_use = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_n   = '0;
    div_d   = '0;
    case (state_q)
      sisu_pkg::S_SQ:    begin mul_use = 1'b1; mul_a = 64'(a_q); mul_b = 64'(a_q); end
      sisu_pkg::S_PM:    begin mul_use = 1'b1; mul_a = term_q; mul_b = a2_q; end
      sisu_pkg::S_PNUM:  begin mul_use = 1'b1; mul_a = p_q; mul_b = 64'(twon - (NW+1)'(1)); end
      sisu_pkg::S_PDEN:  begin mul_use = 1'b1; mul_a = 64'(kf); mul_b = 64'(alt); end
      sisu_pkg::S_AM:    begin mul_use = 1'b1; mul_a = term_q; mul_b = 64'(kf); end
      sisu_pkg::S_RED:   begin
        mul_use = 1'b1; mul_a = 64'(a_q); mul_b = sisu_pkg::TWO_OVER_PI_Q64;
      end
      sisu_pkg::S_PHI:   begin
        mul_use = 1'b1; mul_a = 64'(phr_q); mul_b = sisu_pkg::HALF_PI_Q60;
      end
      sisu_pkg::S_TM:    begin mul_use = 1'b1; mul_a = term_q; mul_b = phi_q; end
      sisu_pkg::S_MF:    begin mul_use = 1'b1; mul_a = cs_mag; mul_b = tmp_q; end
      sisu_pkg::S_MG:    begin mul_use = 1'b1; mul_a = sn_mag; mul_b = tmp_q; end
      sisu_pkg::S_PDIV:  begin div_use = 1'b1; div_n = dvd_q; div_d = den_q; end
      sisu_pkg::S_AD:    begin div_use = 1'b1; div_n = {p_q, 32'd0}; div_d = a2_q; end
      sisu_pkg::S_GINIT: begin div_use = 1'b1; div_n = sisu_pkg::ONE_Q56; div_d = 64'(a_q); end
      sisu_pkg::S_TDIV:  begin div_use = 1'b1; div_n = 96'(p_q); div_d = 64'(j_q) + 64'd1; end
      sisu_pkg::S_SDF:   begin div_use = 1'b1; div_n = {16'd0, f_mag, 16'd0}; div_d = 64'(a_q); end
      sisu_pkg::S_SDG:   begin div_use = 1'b1; div_n = {16'd0, g_mag, 16'd0}; div_d = 64'(a_q); end
      default:           begin mul_use = 1'b0; end
    endcase
  end

  assign mul_start = mul_use && !issued_q;
  assign div_start = div_use && !issued_q;

  sisu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  sisu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign tq      = sisu_pkg::sat_lim({32'd0, quot});
  assign mq40    = sisu_pkg::sat_lim(prod >> 40);
  assign sum_new = sisu_pkg::add_sat(sum_q, tq, n_q[0]);
  assign prod_s  = tneg_q ? -$signed(mq40) : $signed(mq40);

  assign vs      = neg_q ? -acc_q : acc_q;
  assign vmag    = vs[63] ? 64'(-vs) : 64'(vs);
  assign mr      = 53'((vmag + 64'd1024) >> 11);

  always_comb begin
    if (vs[63]) begin
      rounded = (mr > 53'h8000_0000) ? 32'h8000_0000 : 32'(-mr);
    end else begin
      rounded = (mr > 53'h7FFF_FFFF) ? 32'h7FFF_FFFF : mr[31:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    ovalid_d = ovalid_q;
    out_d    = out_q;
    a_d = a_q;  neg_d = neg_q;  a2_d = a2_q;  lim_d = lim_q;
    term_d = term_q;  sum_d = sum_q;  f_d = f_q;  n_d = n_q;  odd_d = odd_q;
    p_d = p_q;  dvd_d = dvd_q;  den_d = den_q;  quad_d = quad_q;  phr_d = phr_q;
    phi_d = phi_q;  s0_d = s0_q;  c0_d = c0_q;  j_d = j_q;  tmp_d = tmp_q;
    tneg_d = tneg_q;  acc_d = acc_q;

    if (ovalid_q && si_o.ready) begin
      ovalid_d = 1'b0;
    end
    if (mul_start || div_start) begin
      issued_d = 1'b1;
    end
    if (mul_done || div_done) begin
      issued_d = 1'b0;
    end

    case (state_q)
      sisu_pkg::S_IDLE: begin
        if (x_i.valid) begin
          neg_d   = x_i.x_value[31];
          a_d     = x_i.x_value[31] ? 32'(-x_i.x_value) : 32'(x_i.x_value);
          lim_d   = {thr_q, 11'd0};
          state_d = sisu_pkg::S_SQ;
        end
      end
      sisu_pkg::S_SQ: begin
        if (mul_done) begin
          a2_d = prod[63:0];
          n_d  = NW'(1);
          if (a_q <= sisu_pkg::FOURTEEN_Q16) begin
            term_d  = {8'd0, a_q, 24'd0};
            sum_d   = $signed({8'd0, a_q, 24'd0});
            odd_d   = 1'b1;
            state_d = sisu_pkg::S_PM;
          end else begin
            term_d  = sisu_pkg::ONE_Q40;
            sum_d   = $signed(sisu_pkg::ONE_Q40);
            odd_d   = 1'b0;
            state_d = sisu_pkg::S_AM;
          end
        end
      end
      sisu_pkg::S_PM: begin
        if (mul_done) begin
          p_d     = sisu_pkg::sat_lim(prod >> 32);
          state_d = sisu_pkg::S_PNUM;
        end
      end
      sisu_pkg::S_PNUM: begin
        if (mul_done) begin
          dvd_d   = prod[95:0];
          state_d = sisu_pkg::S_PDEN;
        end
      end
      sisu_pkg::S_PDEN: begin
        if (mul_done) begin
          den_d   = prod[63:0];
          state_d = sisu_pkg::S_PDIV;
        end
      end
      sisu_pkg::S_PDIV: begin
        if (div_done) begin
          term_d = tq;
          sum_d  = sum_new;
          if (tq <= 64'(lim_q) || n_q == NW'(MAX_TERMS - 1)) begin
            acc_d   = sum_new;
            state_d = sisu_pkg::S_FIN;
          end else begin
            n_d     = n_q + NW'(1);
            state_d = sisu_pkg::S_PM;
          end
        end
      end
      sisu_pkg::S_AM: begin
        if (mul_done) begin
          p_d     = sisu_pkg::sat_lim(prod);
          state_d = sisu_pkg::S_AD;
        end
      end
      sisu_pkg::S_AD: begin
        if (div_done) begin
          term_d = tq;
          sum_d  = sum_new;
          if (tq <= 64'(lim_q) || n_q == NW'(MAX_TERMS - 1)) begin
            if (!odd_q) begin
              f_d     = sum_new;
              state_d = sisu_pkg::S_GINIT;
            end else begin
              state_d = sisu_pkg::S_RED;
            end
          end else begin
            n_d     = n_q + NW'(1);
            state_d = sisu_pkg::S_AM;
          end
        end
      end
      sisu_pkg::S_GINIT: begin
        if (div_done) begin
          term_d  = tq;
          sum_d   = $signed(tq);
          n_d     = NW'(1);
          odd_d   = 1'b1;
          state_d = sisu_pkg::S_AM;
        end
      end
      sisu_pkg::S_RED: begin
        if (mul_done) begin
          quad_d  = prod[81:80];
          phr_d   = prod[79:40];
          state_d = sisu_pkg::S_PHI;
        end
      end
      sisu_pkg::S_PHI: begin
        if (mul_done) begin
          phi_d   = sisu_pkg::sat_lim(prod >> 60);
          term_d  = sisu_pkg::ONE_Q40;
          j_d     = '0;
          s0_d    = '0;
          c0_d    = '0;
          state_d = sisu_pkg::S_TACC;
        end
      end
      sisu_pkg::S_TACC: begin
        case (j_q[1:0])
          2'd0:    c0_d = c0_q + $signed(term_q);
          2'd1:    s0_d = s0_q + $signed(term_q);
          2'd2:    c0_d = c0_q - $signed(term_q);
          default: s0_d = s0_q - $signed(term_q);
        endcase
        state_d = (j_q == sisu_pkg::TAYLOR_LAST) ? sisu_pkg::S_SDF : sisu_pkg::S_TM;
      end
      sisu_pkg::S_TM: begin
        if (mul_done) begin
          p_d     = mq40;
          state_d = sisu_pkg::S_TDIV;
        end
      end
      sisu_pkg::S_TDIV: begin
        if (div_done) begin
          term_d  = tq;
          j_d     = j_q + 5'd1;
          state_d = sisu_pkg::S_TACC;
        end
      end
      sisu_pkg::S_SDF: begin
        if (div_done) begin
          tmp_d   = tq;
          tneg_d  = f_q[63] ^ cs[63];
          state_d = sisu_pkg::S_MF;
        end
      end
      sisu_pkg::S_MF: begin
        if (mul_done) begin
          acc_d   = $signed(sisu_pkg::HALF_PI_Q40) - prod_s;
          state_d = sisu_pkg::S_SDG;
        end
      end
      sisu_pkg::S_SDG: begin
        if (div_done) begin
          tmp_d   = tq;
          tneg_d  = sum_q[63] ^ sn[63];
          state_d = sisu_pkg::S_MG;
        end
      end
      sisu_pkg::S_MG: begin
        if (mul_done) begin
          acc_d   = acc_q - prod_s;
          state_d = sisu_pkg::S_FIN;
        end
      end
      sisu_pkg::S_FIN: begin
        if (!ovalid_q || si_o.ready) begin
          out_d    = rounded;
          ovalid_d = 1'b1;
          state_d  = sisu_pkg::S_IDLE;
        end
      end
      default: state_d = sisu_pkg::S_IDLE;
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == sisu_pkg::REG_TERM_THRESHOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sisu_pkg::S_IDLE;
      issued_q <= 1'b0;
      ovalid_q <= 1'b0;
      thr_q    <= sisu_pkg::THR_RESET;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      ovalid_q <= ovalid_d;
      if (cfg_wr) begin
        thr_q <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    a_q <= a_d;  neg_q <= neg_d;  a2_q <= a2_d;  lim_q <= lim_d;
    term_q <= term_d;  sum_q <= sum_d;  f_q <= f_d;  n_q <= n_d;  odd_q <= odd_d;
    p_q <= p_d;  dvd_q <= dvd_d;  den_q <= den_d;  quad_q <= quad_d;  phr_q <= phr_d;
    phi_q <= phi_d;  s0_q <= s0_d;  c0_q <= c0_d;  j_q <= j_d;  tmp_q <= tmp_d;
    tneg_q <= tneg_d;  acc_q <= acc_d;
  end

  assign x_i.ready     = (state_q == sisu_pkg::S_IDLE);
  assign si_o.valid    = ovalid_q;
  assign si_o.si_value = out_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == sisu_pkg::REG_TERM_THRESHOLD) ? {16'd0, thr_q} : 32'd0;

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_mul_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> issued_q)
    else $error("multiplier finished with no request pending");

  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> issued_q)
    else $error("divider finished with no request pending");

  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sisu_pkg::S_FIN && (!ovalid_q || si_o.ready)) |=> ovalid_q)
    else $error("finished word not presented");

endmodule

`default_nettype wire
